@@ rtl/http_chunked_transfer_decoder_top_defines.svh @@
// Assertion macros shared by the chunked transfer decoder RTL.
// Needs nothing else; files that check their own logic include it by name.
// The checks compile out when SYNTHESIS is defined.
`ifndef HTTP_CHUNKED_TRANSFER_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_TRANSFER_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CHTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define CHTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CHTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define CHTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/chtd_pkg.sv @@
// Types, character codes and helpers for the chunked transfer decoder.
// No dependencies; used by the framer, the output register and the top level.
package chtd_pkg;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_SKIP  = 6'b000001,
    PH_SIZE  = 6'b000010,
    PH_TRAIL = 6'b000100,
    PH_DATA  = 6'b001000,
    PH_DONE  = 6'b010000,
    PH_HALT  = 6'b100000
  } phase_e;

  // Result kinds as seen on the output channel.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // Characters that matter to the framing.
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_VT  = 8'h0b;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] HEX_TEN = 8'd10;

  // One result word handed from the framer to the output register.
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
  } result_t;

  // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [7:0] v;
    logic [4:0] r;
    v = 8'd0;
    r = 5'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      v = ch - CH_0;
      r = {1'b1, v[3:0]};
    end else if (ch >= CH_LA && ch <= CH_LF_HEX) begin
      v = ch - CH_LA + HEX_TEN;
      r = {1'b1, v[3:0]};
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      v = ch - CH_UA + HEX_TEN;
      r = {1'b1, v[3:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/chtd_in_if.sv @@
// Input channel of the chunked transfer decoder: one raw body byte per word.
// No dependencies.
interface chtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_message;

  modport source (output valid, output in_byte, output new_message, input ready);
  modport sink   (input valid, input in_byte, input new_message, output ready);
endinterface

@@ rtl/chtd_out_if.sv @@
// Output channel of the chunked transfer decoder: one result per word.
// No dependencies.
interface chtd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;

  modport source (output valid, output kind, output out_byte, input ready);
  modport sink   (input valid, input kind, input out_byte, output ready);
endinterface

@@ rtl/http_chunked_transfer_decoder_top.sv @@
// HTTP chunked body decoder: takes one raw body byte per word and returns
// the chunk payload bytes, an end word on the zero-size chunk, or an error
// word on bad framing. It accepts one byte every clock cycle while the output
// side keeps up; a byte's result appears in the output register on the
// following cycle. The rate is set by the single framer state update per
// byte, which sits between the input handshake and the result register.
// Bytes that produce no result are accepted under the same condition. Raising
// new_message with a byte restarts the parser before that byte.
module http_chunked_transfer_decoder_top #(
  parameter int LEN_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  chtd_in_if.sink   in_i,
  chtd_out_if.source out_o
);
  import chtd_pkg::*;

  result_t res;
  logic    can_load;
  logic    accept;

  // A byte is taken whenever the result register has room for its result.
  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  chtd_framer #(
    .LEN_BITS(LEN_BITS)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_i.in_byte),
    .new_message_i(in_i.new_message),
    .res_o        (res)
  );

  chtd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .res_i     (res),
    .can_load_o(can_load),
    .out_o     (out_o)
  );
endmodule

@@ rtl/chtd_framer.sv @@
// Framing state machine: size-line parser and chunk data counter.
// Depends on chtd_pkg and the assertion macro header.
`include "http_chunked_transfer_decoder_top_defines.svh"
module chtd_framer #(
  parameter int LEN_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             new_message_i,
  output chtd_pkg::result_t res_o
);
  import chtd_pkg::*;

  phase_e              phase_q, phase_d, phase_e_s;
  logic [LEN_BITS-1:0] size_q, size_d, size_e;
  logic [LEN_BITS-1:0] size_dec;
  logic                cr_q, cr_d, cr_e;
  logic [4:0]          hex;
  logic                is_digit;
  logic                is_blank;
  result_t             res;

  // A new message restarts the parser before this byte is looked at.
  always_comb begin
    phase_e_s = new_message_i ? PH_SKIP : phase_q;
    size_e    = new_message_i ? '0 : size_q;
    cr_e      = new_message_i ? 1'b0 : cr_q;
  end

  assign hex      = hex_decode(in_byte_i);
  assign is_digit = hex[4];
  assign is_blank = (in_byte_i == CH_SP) || (in_byte_i == CH_TAB);
  assign size_dec = size_e - {{(LEN_BITS-1){1'b0}}, 1'b1};

  // Next state and the result for this byte.
  always_comb begin
    phase_d    = phase_e_s;
    size_d     = size_e;
    cr_d       = cr_e;
    res.valid  = 1'b0;
    res.kind   = KIND_DATA;
    res.data   = 8'd0;
    if (cr_e) begin
      // Only LF may follow the CR that ended a size line.
      cr_d = 1'b0;
      if (in_byte_i == CH_LF) begin
        if (size_e == '0) begin
          phase_d   = PH_DONE;
          res.valid = 1'b1;
          res.kind  = KIND_END;
        end else begin
          phase_d = PH_DATA;
        end
      end else begin
        phase_d   = PH_HALT;
        res.valid = 1'b1;
        res.kind  = KIND_ERR;
      end
    end else begin
      case (phase_e_s)
        PH_SKIP: begin
          if (in_byte_i inside {CH_SP, CH_TAB, CH_CR, CH_LF, CH_VT}) begin
            phase_d = PH_SKIP;
          end else if (is_digit) begin
            size_d  = {{(LEN_BITS-4){1'b0}}, hex[3:0]};
            phase_d = PH_SIZE;
          end else begin
            phase_d   = PH_HALT;
            res.valid = 1'b1;
            res.kind  = KIND_ERR;
          end
        end
        PH_SIZE, PH_TRAIL: begin
          if (is_digit && phase_e_s == PH_SIZE) begin
            // A digit that would shift set bits out of the counter is an overflow.
            if (size_e[LEN_BITS-1 -: 4] != 4'd0) begin
              phase_d   = PH_HALT;
              res.valid = 1'b1;
              res.kind  = KIND_ERR;
            end else begin
              size_d = {size_e[LEN_BITS-5:0], hex[3:0]};
            end
          end else if (is_blank) begin
            phase_d = PH_TRAIL;
          end else if (in_byte_i == CH_CR) begin
            cr_d = 1'b1;
          end else if (in_byte_i == CH_LF) begin
            if (size_e == '0) begin
              phase_d   = PH_DONE;
              res.valid = 1'b1;
              res.kind  = KIND_END;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            phase_d   = PH_HALT;
            res.valid = 1'b1;
            res.kind  = KIND_ERR;
          end
        end
        PH_DATA: begin
          size_d    = size_dec;
          res.valid = 1'b1;
          res.kind  = KIND_DATA;
          res.data  = in_byte_i;
          if (size_dec == '0) begin
            phase_d = PH_SKIP;
          end
        end
        default: begin
          // Done, halted or an unknown code: swallow the byte.
          phase_d = phase_e_s;
        end
      endcase
    end
  end

  // State advances only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      size_q  <= '0;
      cr_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      size_q  <= size_d;
      cr_q    <= cr_d;
    end
  end

  assign res_o = res;

  // A pending CR only exists while the size line is open.
  `CHTD_ASSERT_SAME(a_cr_on_size_line, clk_i, rst_ni, cr_q, (phase_q == PH_SIZE) || (phase_q == PH_TRAIL), "CR pending outside the size line")
  // The data phase always has bytes left to pass.
  `CHTD_ASSERT_SAME(a_data_nonzero, clk_i, rst_ni, phase_q == PH_DATA, size_q != '0, "data phase with zero bytes left")
  // An end result leaves the parser in the done phase.
  `CHTD_ASSERT_NEXT(a_end_to_done, clk_i, rst_ni, accept_i && res.valid && (res.kind == KIND_END), phase_q == PH_DONE, "end result without done phase")
  // After end or error nothing comes out until a new message.
  `CHTD_ASSERT_SAME(a_quiet_when_stopped, clk_i, rst_ni, accept_i && !new_message_i && ((phase_q == PH_DONE) || (phase_q == PH_HALT)), !res.valid, "result while stopped")
endmodule

@@ rtl/chtd_out_reg.sv @@
// Result register that drives the output channel.
// Depends on chtd_pkg and the chtd_out_if interface.
module chtd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  chtd_pkg::result_t res_i,
  output logic              can_load_o,
  chtd_out_if.source        out_o
);
  import chtd_pkg::*;

  logic       valid_q, valid_d;
  kind_e      kind_q;
  logic [7:0] data_q;
  logic       load;

  // The register takes a new word when empty or when its word leaves now.
  assign can_load_o = !valid_q || out_o.ready;
  assign load       = accept_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= res_i.kind;
      data_q <= res_i.data;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.kind     = kind_q;
  assign out_o.out_byte = data_q;
endmodule

@@ tb/tb_http_chunked_transfer_decoder_top.sv @@
// Self-checking testbench for http_chunked_transfer_decoder_top.
// Depends on chtd_pkg and the chtd_in_if / chtd_out_if channel interfaces.
// Feeds framed, truncated and broken chunked bodies and checks each result word.
module tb_http_chunked_transfer_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import chtd_pkg::*;

  localparam int LEN_BITS    = 32;
  localparam int ITEM_TARGET = 900;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int TAIL_CYCLES = 4;

  // One raw body byte as queued for the driver.
  typedef struct packed {
    logic [7:0] ch;
    logic       restart;
    logic       hold;
  } raw_byte_t;

  // One result word as the decoder should produce it.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } dec_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  chtd_in_if  in_if ();
  chtd_out_if out_if ();

  http_chunked_transfer_decoder_top #(.LEN_BITS(LEN_BITS)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  raw_byte_t byte_q[$];
  dec_word_t decoded_words_q[$];
  int        feed_total;
  int        body_cnt;
  logic      restart_next;
  logic      hold_next;
  int        words_pending;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        fail_cnt;
  int        cycle_cnt;

  // Framing state of the decoder as the checker sees it.
  phase_e              frm_phase;
  logic [LEN_BITS-1:0] frm_left;
  logic                frm_cr;

  // Value of a hex digit in either case, or -1 for anything else.
  function automatic int hex_value(input logic [7:0] ch);
    if (ch >= CH_0 && ch <= CH_9) return int'(ch - CH_0);
    if (ch >= CH_LA && ch <= CH_LF_HEX) return int'(ch - CH_LA) + 10;
    if (ch >= CH_UA && ch <= CH_UF) return int'(ch - CH_UA) + 10;
    return -1;
  endfunction

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == CH_SP || ch == CH_TAB || ch == CH_CR || ch == CH_LF || ch == CH_VT;
  endfunction

  // Advance the framing state by one byte and give the word it yields, if any.
  function automatic void frame_byte(input logic [7:0] ch, input logic restart,
                                     output logic got, output dec_word_t w);
    int   d;
    logic do_fail;
    logic do_line;
    got     = 1'b0;
    w.kind  = KIND_DATA;
    w.data  = 8'd0;
    do_fail = 1'b0;
    do_line = 1'b0;
    d       = hex_value(ch);
    if (restart) begin
      frm_phase = PH_SKIP;
      frm_left  = '0;
      frm_cr    = 1'b0;
    end
    if (frm_cr) begin
      // A CR on the size line must be followed by LF straight away.
      if (ch == CH_LF) do_line = 1'b1;
      else do_fail = 1'b1;
    end else begin
      case (frm_phase)
        PH_SKIP: begin
          if (!is_blank(ch)) begin
            if (d >= 0) begin
              frm_left  = LEN_BITS'(d);
              frm_phase = PH_SIZE;
            end else begin
              do_fail = 1'b1;
            end
          end
        end
        PH_SIZE: begin
          if (d >= 0) begin
            // A further digit must not shift set bits out of the counter.
            if (frm_left[LEN_BITS-1 -: 4] != 4'd0) do_fail = 1'b1;
            else frm_left = {frm_left[LEN_BITS-5:0], 4'(d)};
          end else if (ch == CH_SP || ch == CH_TAB) begin
            frm_phase = PH_TRAIL;
          end else if (ch == CH_CR) begin
            frm_cr = 1'b1;
          end else if (ch == CH_LF) begin
            do_line = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (ch == CH_CR) frm_cr = 1'b1;
          else if (ch == CH_LF) do_line = 1'b1;
          else if (ch != CH_SP && ch != CH_TAB) do_fail = 1'b1;
        end
        PH_DATA: begin
          frm_left = frm_left - 1'b1;
          if (frm_left == '0) frm_phase = PH_SKIP;
          got    = 1'b1;
          w.kind = KIND_DATA;
          w.data = ch;
        end
        default: ;
      endcase
    end
    if (do_fail) begin
      frm_phase = PH_HALT;
      frm_cr    = 1'b0;
      got       = 1'b1;
      w.kind    = KIND_ERR;
    end
    if (do_line) begin
      frm_cr = 1'b0;
      if (frm_left == '0) begin
        frm_phase = PH_DONE;
        got       = 1'b1;
        w.kind    = KIND_END;
      end else begin
        frm_phase = PH_DATA;
      end
    end
  endfunction

  // Queue one body byte; the pending restart and hold flags go with it.
  function automatic void put(input logic [7:0] ch, input bit counted = 1'b1);
    raw_byte_t b;
    b.ch         = ch;
    b.restart    = restart_next;
    b.hold       = hold_next;
    restart_next = 1'b0;
    hold_next    = 1'b0;
    byte_q.push_back(b);
    if (counted) body_cnt++;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_LF;
      default: return CH_VT;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_0 + 8'(v);
    if ($urandom_range(0, 1) == 1) return CH_UA + 8'(v) - 8'd10;
    return CH_LA + 8'(v) - 8'd10;
  endfunction

  // A byte that is neither a hex digit nor allowed after the digits.
  function automatic logic [7:0] junk_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (hex_value(ch) >= 0 || ch == CH_SP || ch == CH_TAB || ch == CH_CR || ch == CH_LF);
    return ch;
  endfunction

  function automatic void put_digits(input logic [LEN_BITS-1:0] size);
    int nd;
    nd = 1;
    while (nd < LEN_BITS / 4 && (size >> (4 * nd)) != '0) nd++;
    repeat (($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 10))
      put(CH_0);
    for (int i = nd - 1; i >= 0; i--) put(hex_char(size[4*i +: 4]));
  endfunction

  // A size line with optional leading blanks, trailing spaces and either ending.
  function automatic void put_size_line(input logic [LEN_BITS-1:0] size);
    repeat ($urandom_range(0, 2)) put(blank_char());
    put_digits(size);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put(($urandom_range(0, 1) == 1) ? CH_SP : CH_TAB);
    if ($urandom_range(0, 1) == 1) put(CH_CR);
    put(CH_LF);
  endfunction

  function automatic void put_chunk();
    int sz;
    sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    put_size_line(sz);
    repeat (sz) put(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) begin
      put(CH_CR);
      put(CH_LF);
    end
  endfunction

  // Bytes after an end or error word are ignored until the next restart.
  function automatic void put_ignored();
    repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // A complete body: a few chunks, then the zero chunk.
  function automatic void put_body();
    restart_next = 1'b1;
    repeat ($urandom_range(0, 3)) put_chunk();
    put_size_line('0);
    put_ignored();
  endfunction

  // A body cut short inside a chunk, often one with a huge size.
  function automatic void put_truncated();
    restart_next = 1'b1;
    if ($urandom_range(0, 1) == 1) put_size_line(LEN_BITS'($urandom) | 1'b1);
    else put_size_line('1);
    repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
  endfunction

  // A body with a framing fault, sometimes after a good chunk.
  function automatic void put_broken();
    logic [7:0] ch;
    restart_next = 1'b1;
    if ($urandom_range(0, 2) == 0) put_chunk();
    case ($urandom_range(0, 5))
      0: begin
        // Bad first character after the blanks.
        repeat ($urandom_range(0, 2)) put(blank_char());
        do ch = 8'($urandom_range(0, 255));
        while (hex_value(ch) >= 0 || is_blank(ch));
        put(ch);
      end
      1: begin
        put_digits($urandom_range(1, 255));
        put(junk_char());
      end
      2: begin
        // Chunk extension.
        put_digits($urandom_range(1, 255));
        put(";");
        put("x");
        put("=");
        put("1");
      end
      3: begin
        // Junk after trailing spaces.
        put_digits($urandom_range(1, 255));
        repeat ($urandom_range(1, 3)) put(($urandom_range(0, 1) == 1) ? CH_SP : CH_TAB);
        put(junk_char());
      end
      4: begin
        // CR without LF.
        put_digits($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 1) put(CH_SP);
        put(CH_CR);
        do ch = 8'($urandom_range(0, 255));
        while (ch == CH_LF);
        put(ch);
      end
      default: begin
        // Size overflow: nine significant digits.
        put(hex_char(4'($urandom_range(1, 15))));
        repeat (LEN_BITS / 4) put(hex_char(4'($urandom_range(0, 15))));
      end
    endcase
    put_ignored();
  endfunction

  function automatic void put_noise();
    restart_next = ($urandom_range(0, 1) == 1);
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 9) == 0) restart_next = 1'b1;
      put(8'($urandom_range(0, 255)));
    end
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    int r;
    rst_ni            = 1'b0;
    body_cnt          = 0;
    restart_next      = 1'b0;
    hold_next         = 1'b0;

    // Directed: all blanks, trailing space and tab, data extremes, zero chunk.
    restart_next = 1'b1;
    put(CH_SP);
    put(CH_TAB);
    put(CH_VT);
    put(CH_CR);
    put(CH_LF);
    put(CH_0);
    put("2");
    put(CH_SP);
    put(CH_TAB);
    put(CH_CR);
    put(CH_LF);
    put(8'h00);
    put(8'hff);
    put(CH_0);
    put(CH_LF);
    put("Z", 1'b0);
    // Directed faults: bad first character, extension, junk after spaces, CR alone.
    restart_next = 1'b1;
    put("g");
    restart_next = 1'b1;
    put("F");
    put(";");
    restart_next = 1'b1;
    put("a");
    put(CH_SP);
    put("x");
    restart_next = 1'b1;
    put("A");
    put(CH_CR);
    put("A");

    // Random bodies; the first one waits for the decoder to drain.
    hold_next = 1'b1;
    while (body_cnt < ITEM_TARGET) begin
      if ($urandom_range(0, 29) == 0) hold_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 60) put_body();
      else if (r < 72) put_truncated();
      else if (r < 92) put_broken();
      else put_noise();
    end
    feed_total = byte_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || in_if.valid) @(negedge clk_i);
    while (decoded_words_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0 && decoded_words_q.size() == 0) begin
      $display("http_chunked_transfer_decoder_top test passed");
    end else begin
      $display("http_chunked_transfer_decoder_top test failed");
    end
    $finish;
  end

  // Driver: presents queued bytes, idling at the rate of the current stretch.
  always @(posedge clk_i) begin : feed_proc
    raw_byte_t cur;
    logic      offer;
    int        left;
    left = byte_q.size();
    if (left * 3 > feed_total * 2) begin
      send_idle_pct <= 37;
      recv_idle_pct <= 86;
    end else if (left * 3 > feed_total) begin
      send_idle_pct <= 86;
      recv_idle_pct <= 37;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      offer = 1'b0;
      if (left != 0) begin
        offer = ($urandom_range(0, 99) >= send_idle_pct);
        // A held byte waits until every word owed so far has been taken.
        if (byte_q[0].hold && (in_if.valid || words_pending != 0)) offer = 1'b0;
      end
      if (offer) begin
        cur = byte_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.in_byte     <= cur.ch;
        in_if.new_message <= cur.restart;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at the rate of the current stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predicts on each accepted byte, checks each accepted word.
  always @(posedge clk_i) begin : check_proc
    logic      got;
    dec_word_t w;
    dec_word_t want;
    int        pushed;
    int        popped;
    pushed = 0;
    popped = 0;
    if (!rst_ni) begin
      frm_phase     = PH_SKIP;
      frm_left      = '0;
      frm_cr        = 1'b0;
      words_pending <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        frame_byte(in_if.in_byte, in_if.new_message, got, w);
        if (got) begin
          decoded_words_q.push_back(w);
          pushed = 1;
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (decoded_words_q.size() == 0) begin
          $display("%0t: word with none expected: kind %0d byte %02h",
                   $time, out_if.kind, out_if.out_byte);
          fail_cnt++;
        end else begin
          want   = decoded_words_q.pop_front();
          popped = 1;
          if (out_if.kind !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d actual %0d",
                     $time, want.kind, out_if.kind);
            fail_cnt++;
          end
          if (out_if.out_byte !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h actual %02h",
                     $time, want.data, out_if.out_byte);
            fail_cnt++;
          end
        end
      end
      words_pending <= words_pending + pushed - popped;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("http_chunked_transfer_decoder_top test failed");
      $finish;
    end
  end

endmodule
